### rtl/pwm_duty_regulator_soft_start_top_assert.svh
// Assertion macros shared by the duty regulator RTL.
`ifndef PWM_DUTY_REGULATOR_SOFT_START_TOP_ASSERT_SVH
`define PWM_DUTY_REGULATOR_SOFT_START_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked property, off while reset is asserted.
`define PDR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pdr assertion failed");
// Checked property, active in reset as well.
`define PDR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pdr assertion failed");
`else
`define PDR_ASSERT(lbl, clk, rst_n, prop)
`define PDR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/pdr_pkg.sv
// Shared types and constants of the duty regulator.
package pdr_pkg;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned DUTY_W  = 8;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic [2:0] {
    REG_TARGET_LEVEL  = 3'd0,
    REG_DUTY_MAX      = 3'd1,
    REG_LIMIT_STEP    = 3'd2,
    REG_LIMIT_INIT    = 3'd3,
    REG_RESTART_TICKS = 3'd4
  } reg_idx_e;

  localparam logic [LEVEL_W-1:0] TARGET_LEVEL_RST  = 10'd512;
  localparam logic [DUTY_W-1:0]  DUTY_MAX_RST      = 8'd127;
  localparam logic [DUTY_W-1:0]  LIMIT_STEP_RST    = 8'd16;
  localparam logic [DUTY_W-1:0]  LIMIT_INIT_RST    = 8'd0;
  localparam logic [DUTY_W-1:0]  RESTART_TICKS_RST = 8'd100;

  typedef struct packed {
    logic [LEVEL_W-1:0] target_level;
    logic [DUTY_W-1:0]  duty_max;
    logic [DUTY_W-1:0]  limit_step;
    logic [DUTY_W-1:0]  limit_init;
    logic [DUTY_W-1:0]  restart_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              on_target;
    logic              ramping;
  } result_t;

endpackage

### rtl/pdr_cfg.sv
// APB register file holding the regulator settings.
module pdr_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pdr_pkg::ADDR_W-1:0] paddr,
  input  logic [pdr_pkg::DATA_W-1:0] pwdata,
  output logic [pdr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output pdr_pkg::cfg_t              cfg_o
);
  import pdr_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_level  <= TARGET_LEVEL_RST;
      cfg_q.duty_max      <= DUTY_MAX_RST;
      cfg_q.limit_step    <= LIMIT_STEP_RST;
      cfg_q.limit_init    <= LIMIT_INIT_RST;
      cfg_q.restart_ticks <= RESTART_TICKS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TARGET_LEVEL:  cfg_q.target_level  <= pwdata[LEVEL_W-1:0];
        REG_DUTY_MAX:      cfg_q.duty_max      <= pwdata[DUTY_W-1:0];
        REG_LIMIT_STEP:    cfg_q.limit_step    <= pwdata[DUTY_W-1:0];
        REG_LIMIT_INIT:    cfg_q.limit_init    <= pwdata[DUTY_W-1:0];
        REG_RESTART_TICKS: cfg_q.restart_ticks <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_LEVEL:  prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_q.target_level};
      REG_DUTY_MAX:      prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_q.duty_max};
      REG_LIMIT_STEP:    prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_q.limit_step};
      REG_LIMIT_INIT:    prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_q.limit_init};
      REG_RESTART_TICKS: prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_q.restart_ticks};
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/pdr_core.sv
// Regulator state and the update it makes for each item.
module pdr_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        kind_i,
  input  logic [pdr_pkg::LEVEL_W-1:0] sample_i,
  input  pdr_pkg::cfg_t               cfg_i,
  output pdr_pkg::result_t            res_o
);
  import pdr_pkg::*;

  `include "pwm_duty_regulator_soft_start_top_assert.svh"

  logic [DUTY_W-1:0]  duty_target_q, duty_target_d;
  logic [LEVEL_W-1:0] last_level_q, last_level_d;
  logic [DUTY_W-1:0]  ramp_count_q, ramp_count_d;
  logic [DUTY_W-1:0]  duty_limit_q, duty_limit_d;
  logic               in_band_q, in_band_d;

  logic               above, below;
  logic [DUTY_W:0]    limit_sum;

  // deadband compares, one bit wider so the +1 cannot wrap
  assign above = {1'b0, sample_i} > ({1'b0, cfg_i.target_level} + 11'd1);
  assign below = ({1'b0, sample_i} + 11'd1) < {1'b0, cfg_i.target_level};
  assign limit_sum = {1'b0, duty_limit_q} + {1'b0, cfg_i.limit_step};

  always_comb begin
    duty_target_d = duty_target_q;
    last_level_d  = last_level_q;
    ramp_count_d  = ramp_count_q;
    duty_limit_d  = duty_limit_q;
    in_band_d     = in_band_q;
    if (kind_i == KIND_SAMPLE) begin
      last_level_d = sample_i;
      if (above) begin
        if (duty_target_q != '0) duty_target_d = duty_target_q - 8'd1;
        in_band_d = 1'b0;
      end else if (below) begin
        if (duty_target_q < cfg_i.duty_max) duty_target_d = duty_target_q + 8'd1;
        in_band_d = 1'b0;
      end else begin
        in_band_d = 1'b1;
      end
    end else begin
      if (ramp_count_q != '0) begin
        ramp_count_d = ramp_count_q - 8'd1;
        duty_limit_d = limit_sum[DUTY_W] ? {DUTY_W{1'b1}} : limit_sum[DUTY_W-1:0];
      end else begin
        duty_limit_d = cfg_i.duty_max;
      end
      // open-circuit restart
      if (ramp_count_d == '0 && last_level_q == '0) begin
        ramp_count_d = cfg_i.restart_ticks;
        duty_limit_d = cfg_i.limit_init;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_target_q <= '0;
      last_level_q  <= '0;
      ramp_count_q  <= LIMIT_STEP_RST;
      duty_limit_q  <= LIMIT_INIT_RST;
      in_band_q     <= 1'b0;
    end else if (step_i) begin
      duty_target_q <= duty_target_d;
      last_level_q  <= last_level_d;
      ramp_count_q  <= ramp_count_d;
      duty_limit_q  <= duty_limit_d;
      in_band_q     <= in_band_d;
    end
  end

  assign res_o.duty      = (duty_target_d < duty_limit_d) ? duty_target_d : duty_limit_d;
  assign res_o.on_target = in_band_d;
  assign res_o.ramping   = (ramp_count_d != '0);

  `PDR_ASSERT(a_duty_clamped, clk_i, rst_ni, step_i |-> (res_o.duty <= duty_limit_d && res_o.duty <= duty_target_d))
  `PDR_ASSERT(a_sample_keeps_ramp, clk_i, rst_ni, (step_i && kind_i == KIND_SAMPLE) |=> (ramp_count_q == $past(ramp_count_q) && duty_limit_q == $past(duty_limit_q)))
  `PDR_ASSERT(a_tick_keeps_target, clk_i, rst_ni, (step_i && kind_i == KIND_TICK) |=> (duty_target_q == $past(duty_target_q) && in_band_q == $past(in_band_q)))

endmodule

### rtl/pwm_duty_regulator_soft_start_top.sv
// Top level of the soft-start PWM duty regulator.
// Data path: an accepted item waits in the input register; the core computes
// its result from the state, and the result register takes it and drives
// the outputs. While the result register is full and out_stall_i is high,
// the input register holds. Throughput: one item per cycle when not stalled.
// Reset (rst_ni low, async): settings return to defaults, duty target and
// last level clear, ramp count loads 16 and the duty limit loads 0.
module pwm_duty_regulator_soft_start_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [pdr_pkg::LEVEL_W-1:0] sample_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pdr_pkg::DUTY_W-1:0]  duty_o,
  output logic                        on_target_o,
  output logic                        ramping_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdr_pkg::ADDR_W-1:0]  paddr,
  input  logic [pdr_pkg::DATA_W-1:0]  pwdata,
  output logic [pdr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import pdr_pkg::*;

  `include "pwm_duty_regulator_soft_start_top_assert.svh"

  cfg_t               cfg;
  result_t            res;

  // input register
  logic               s1_valid_q;
  logic               s1_kind_q;
  logic [LEVEL_W-1:0] s1_sample_q;

  // result register
  logic               out_valid_q;
  result_t            out_q;

  logic               advance;   // item in the input register moves on
  logic               step;
  logic               in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  // the input register takes a new item when empty or when it drains
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  pdr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pdr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .kind_i   (s1_kind_q),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance || in_take) s1_valid_q <= in_take;
      if (advance) out_valid_q <= s1_valid_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q   <= kind_i;
      s1_sample_q <= sample_i;
    end
    if (step) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = out_q.duty;
  assign on_target_o = out_q.on_target;
  assign ramping_o   = out_q.ramping;

  `PDR_ASSERT_ALWAYS(a_stall_needs_item, clk_i, in_stall_o |-> s1_valid_q)
  `PDR_ASSERT(a_step_fills_out, clk_i, rst_ni, step |=> out_valid_q)
  `PDR_ASSERT(a_full_back_pressure, clk_i, rst_ni, (out_valid_q && out_stall_i && s1_valid_q) |-> in_stall_o)

endmodule
